// ===== src/ase_pkg.sv =====
// shared types, character constants and helpers for the alarm sentence encoder
`timescale 1ns / 1ps
`default_nettype none

package ase_pkg;

    localparam int VALUE_W  = 27;
    localparam int BCD_DIGS = 9;

    // one report as it is pushed in
    typedef struct packed {
        logic                 kind;
        logic [VALUE_W-1:0]   value;
        logic [4:0]           hour;
        logic [5:0]           minute;
        logic [5:0]           second;
    } in_item_t;

    // one sentence byte as it is popped out
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    // decoded sentence handed from the front to the back
    typedef struct packed {
        logic            kind;
        logic [5:0][3:0] hms;
        logic [2:0][3:0] nnn;
        logic [4:0][3:0] val;
        logic [7:0]      state_ch;
        logic [7:0]      csum;
    } sent_rec_t;

    localparam logic KIND_ALARM  = 1'b0;
    localparam logic KIND_ANALOG = 1'b1;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_Y      = 8'h59;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return {4'h3, d};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = {4'h3, nib};
        end
        else
        begin
            ch = CH_A + {4'h0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== src/ase_front.sv =====
// front: accepts reports, converts the value to decimal and builds the sentence record
`timescale 1ns / 1ps
`default_nettype none

module ase_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  ase_pkg::in_item_t   item,
    input  wire                 q_full,
    output logic                q_push,
    output ase_pkg::sent_rec_t  q_rec
);

    localparam int BCD_W = 4 * ase_pkg::BCD_DIGS;
    localparam logic [4:0] STEPS = 5'(ase_pkg::VALUE_W);

    logic                        busy_reg, busy_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic [ase_pkg::VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]            bcd_reg, bcd_next;
    logic                        kind_reg, kind_next;
    logic [5:0][3:0]             hms_reg, hms_next;

    logic [BCD_W-1:0]            adj;
    logic                        accept;
    logic                        done;
    logic [ase_pkg::BCD_DIGS-1:0][3:0] d;
    logic [7:0]                  sum;

    // two decimal digits of a value below 64
    function automatic logic [7:0] to_bcd2(input logic [5:0] v);
        logic [3:0] tens;
        logic [5:0] ones;
        if (v >= 6'd60)      tens = 4'd6;
        else if (v >= 6'd50) tens = 4'd5;
        else if (v >= 6'd40) tens = 4'd4;
        else if (v >= 6'd30) tens = 4'd3;
        else if (v >= 6'd20) tens = 4'd2;
        else if (v >= 6'd10) tens = 4'd1;
        else                 tens = 4'd0;
        ones = v - 6'({2'b00, tens} * 6'd10);
        return {tens, ones[3:0]};
    endfunction

    always_comb
    begin
        // add-3 correction of every digit before the shift
        for (int i = 0; i < ase_pkg::BCD_DIGS; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                         : bcd_reg[4*i +: 4];
        end

        done   = busy_reg && (cnt_reg == 5'd0);
        q_push = done && !q_full;
        full   = busy_reg && !q_push;
        accept = push && !full;

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        kind_next = kind_reg;
        hms_next  = hms_reg;

        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = STEPS;
            bin_next  = item.value;
            bcd_next  = '0;
            kind_next = item.kind;
            hms_next  = {to_bcd2({1'b0, item.hour}), to_bcd2(item.minute),
                         to_bcd2(item.second)};
        end
        else if (q_push)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && (cnt_reg != 5'd0))
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[ase_pkg::VALUE_W-1]};
            bin_next = {bin_reg[ase_pkg::VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
        end
    end

    // record assembly and checksum from the finished conversion
    always_comb
    begin
        d = bcd_reg;

        q_rec.kind = kind_reg;
        q_rec.hms  = hms_reg;
        if (kind_reg == ase_pkg::KIND_ALARM)
        begin
            q_rec.nnn = {d[2], d[1], d[0]};
        end
        else
        begin
            q_rec.nnn = {d[7], d[6], d[5]};
        end
        q_rec.val = {d[4], d[3], d[2], d[1], d[0]};

        // value/1000 == 1 means the thousands digit is one and all above it zero
        if ({d[2], d[1], d[0]} == 12'h000)
        begin
            q_rec.state_ch = ase_pkg::CH_B;
        end
        else if ({d[8], d[7], d[6], d[5], d[4]} == 20'h00000 && d[3] == 4'd1)
        begin
            q_rec.state_ch = ase_pkg::CH_A;
        end
        else
        begin
            q_rec.state_ch = ase_pkg::CH_V;
        end

        sum = ase_pkg::CH_X ^ ase_pkg::CH_Y ^ ase_pkg::CH_A ^ ase_pkg::CH_L
            ^ ase_pkg::CH_COMMA ^ ase_pkg::CH_COMMA ^ ase_pkg::CH_COMMA
            ^ ((kind_reg == ase_pkg::KIND_ANALOG) ? ase_pkg::CH_V : ase_pkg::CH_R);
        for (int i = 0; i < 6; i++)
        begin
            sum = sum ^ ase_pkg::digit_char(hms_reg[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            sum = sum ^ ase_pkg::digit_char(q_rec.nnn[i]);
        end
        if (kind_reg == ase_pkg::KIND_ANALOG)
        begin
            for (int i = 0; i < 5; i++)
            begin
                sum = sum ^ ase_pkg::digit_char(q_rec.val[i]);
            end
        end
        else
        begin
            sum = sum ^ q_rec.state_ch;
        end
        q_rec.csum = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        kind_reg <= kind_next;
        hms_reg  <= hms_next;
    end

endmodule

`default_nettype wire

// ===== src/ase_queue.sv =====
// short queue of decoded sentence records between front and back
`timescale 1ns / 1ps
`default_nettype none

module ase_queue #(
    parameter int DEPTH = 2
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 wr,
    input  ase_pkg::sent_rec_t  wr_data,
    output logic                q_full,
    input  wire                 rd,
    output logic                q_empty,
    output ase_pkg::sent_rec_t  rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    ase_pkg::sent_rec_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    always_comb
    begin
        q_full  = (cnt_reg == CNT_MAX);
        q_empty = (cnt_reg == '0);
        do_wr   = wr && !q_full;
        do_rd   = rd && !q_empty;
        rd_data = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_ONE;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/ase_back.sv =====
// back: walks a sentence record byte by byte into the output register
`timescale 1ns / 1ps
`default_nettype none

module ase_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_empty,
    input  ase_pkg::sent_rec_t  q_rec,
    output logic                q_pop,
    output logic                empty,
    input  wire                 pop,
    output ase_pkg::out_item_t  result
);

    localparam logic [4:0] POS_LAST   = 5'd27;
    localparam logic [4:0] ALARM_TAIL = 5'd19;
    localparam logic [4:0] TAIL_SKIP  = 5'd4;

    logic [4:0]         idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    ase_pkg::out_item_t out_reg, out_next;

    logic [4:0]         pos;
    logic [7:0]         ch;
    logic               last;
    logic               advance;
    logic               take;

    always_comb
    begin
        // the alarm sentence has four fewer bytes: its tail maps onto the analog tail
        if (q_rec.kind == ase_pkg::KIND_ALARM && idx_reg >= ALARM_TAIL)
        begin
            pos = idx_reg + TAIL_SKIP;
        end
        else
        begin
            pos = idx_reg;
        end
        last = (pos == POS_LAST);

        case (pos)
            5'd0:  ch = ase_pkg::CH_DOLLAR;
            5'd1:  ch = ase_pkg::CH_X;
            5'd2:  ch = ase_pkg::CH_Y;
            5'd3:  ch = ase_pkg::CH_A;
            5'd4:  ch = ase_pkg::CH_L;
            5'd5:  ch = (q_rec.kind == ase_pkg::KIND_ANALOG) ? ase_pkg::CH_V : ase_pkg::CH_R;
            5'd6:  ch = ase_pkg::CH_COMMA;
            5'd7:  ch = ase_pkg::digit_char(q_rec.hms[5]);
            5'd8:  ch = ase_pkg::digit_char(q_rec.hms[4]);
            5'd9:  ch = ase_pkg::digit_char(q_rec.hms[3]);
            5'd10: ch = ase_pkg::digit_char(q_rec.hms[2]);
            5'd11: ch = ase_pkg::digit_char(q_rec.hms[1]);
            5'd12: ch = ase_pkg::digit_char(q_rec.hms[0]);
            5'd13: ch = ase_pkg::CH_COMMA;
            5'd14: ch = ase_pkg::digit_char(q_rec.nnn[2]);
            5'd15: ch = ase_pkg::digit_char(q_rec.nnn[1]);
            5'd16: ch = ase_pkg::digit_char(q_rec.nnn[0]);
            5'd17: ch = ase_pkg::CH_COMMA;
            5'd18: ch = (q_rec.kind == ase_pkg::KIND_ANALOG)
                        ? ase_pkg::digit_char(q_rec.val[4]) : q_rec.state_ch;
            5'd19: ch = ase_pkg::digit_char(q_rec.val[3]);
            5'd20: ch = ase_pkg::digit_char(q_rec.val[2]);
            5'd21: ch = ase_pkg::digit_char(q_rec.val[1]);
            5'd22: ch = ase_pkg::digit_char(q_rec.val[0]);
            5'd23: ch = ase_pkg::CH_STAR;
            5'd24: ch = ase_pkg::hex_char(q_rec.csum[7:4]);
            5'd25: ch = ase_pkg::hex_char(q_rec.csum[3:0]);
            5'd26: ch = ase_pkg::CH_CR;
            5'd27: ch = ase_pkg::CH_LF;
            default: ch = 8'h00;
        endcase

        // output register reloads when it is empty or its byte is taken
        advance = !out_valid_reg || pop;
        take    = advance && !q_empty;
        q_pop   = take && last;
        empty   = !out_valid_reg;
        result  = out_reg;

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next = !q_empty;
        end
        if (take)
        begin
            out_next.out_byte  = ch;
            out_next.last_byte = last;
            idx_next           = last ? 5'd0 : idx_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== src/alarm_sentence_encoder_core.sv =====
// top level of the alarm sentence encoder
//
// usage: reports are pushed on the input queue port (push, full, item); a transfer
// happens at a clock edge with push high and full low. each report comes out as
// an ascii sentence, one byte per transfer on the result queue port (empty, pop,
// result): 24 bytes for the alarm kind, 28 for the analog kind, with last_byte
// set on the closing line feed.
// a report passes the front end converter, the record queue and the back end
// output register before its first byte shows on result. throughput: the
// 27-step binary to decimal converter in the front end takes a new report once
// the last is queued; the back end emits one byte per cycle while pop is high.
// stall: when pop stays low the output register holds its byte, the record
// queue (QUEUE_DEPTH sentences) fills, and then full stays high until space frees up.
// reset: rst_n clears all control state; the block comes up empty and ready.
`timescale 1ns / 1ps
`default_nettype none

module alarm_sentence_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  ase_pkg::in_item_t   item,
    output logic                empty,
    input  wire                 pop,
    output ase_pkg::out_item_t  result
);

    logic               fq_push;
    logic               fq_full;
    ase_pkg::sent_rec_t fq_wr_rec;
    logic               bq_pop;
    logic               bq_empty;
    ase_pkg::sent_rec_t bq_rd_rec;

    ase_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_full (fq_full),
        .q_push (fq_push),
        .q_rec  (fq_wr_rec)
    );

    ase_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fq_push),
        .wr_data (fq_wr_rec),
        .q_full  (fq_full),
        .rd      (bq_pop),
        .q_empty (bq_empty),
        .rd_data (bq_rd_rec)
    );

    ase_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (bq_empty),
        .q_rec   (bq_rd_rec),
        .q_pop   (bq_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== src/ase_checker.sv =====
// port-level checker for the alarm sentence encoder and its bind
`timescale 1ns / 1ps
`default_nettype none

module ase_checker (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 empty,
    input  wire                 pop,
    input  ase_pkg::out_item_t  result
);

    logic start_reg;

    // set while the next byte shown opens a new sentence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
        end
        else if (pop && !empty)
        begin
            start_reg <= result.last_byte;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

    a_first_dollar: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && start_reg) |-> (result.out_byte == ase_pkg::CH_DOLLAR))
        else $error("sentence does not open with dollar sign");

    a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.last_byte) |-> (result.out_byte == ase_pkg::CH_LF))
        else $error("last byte is not a line feed");

    a_lf_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.out_byte == ase_pkg::CH_LF) |-> result.last_byte)
        else $error("line feed not marked as last byte");

endmodule

bind alarm_sentence_encoder_core ase_checker u_ase_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire
